// File: hw/rtl/encoder_speed_loop_macros.svh
// ----------------------------------------------------------------------------
// Encoder speed loop assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_LOOP_MACROS_SVH
`define ENCODER_SPEED_LOOP_MACROS_SVH

// ante |-> cons, same cycle
`define ESL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante |=> cons, next cycle
`define ESL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/esl_pkg.sv
// ----------------------------------------------------------------------------
// esl_pkg
// Shared constants, types and states of the encoder speed loop.
// ----------------------------------------------------------------------------
`default_nettype none

package esl_pkg;

    localparam int DPC_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int CNT_W   = 32;
    localparam int PROD_W  = 48;          // 32 x 16 shared multiplier
    localparam int NUM_W   = 62;          // |step| * 15625
    localparam int DIV_D_W = 34;          // elapsed_us * 4
    localparam int DIV_Q_W = 17;          // quotient bits kept before clamping
    localparam int DIV_CNT_W = 5;
    localparam int ADDR_W  = 3;

    localparam logic [DPC_W-1:0]  DPC_RESET  = 16'd1618;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd768;
    localparam logic [15:0]       SPEED_SCALE = 16'd15625;   // 1e6 / 64
    localparam logic signed [25:0] DRIVE_MAX = 26'sd25600;
    localparam logic signed [25:0] DRIVE_MIN = -26'sd25600;

    // register index, taken from paddr[2]
    localparam logic REG_DPC  = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    typedef struct packed {
        logic [DPC_W-1:0]  dpc;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ERR,
        S_CORR,
        S_DRIVE
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/esl_in_if.sv
// ----------------------------------------------------------------------------
// esl_in_if
// Tick channel: encoder count, timestamp, target speed, clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface esl_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        encoder_count;
    logic [31:0]        time_us;
    logic signed [15:0] target_speed;
    logic               clear_distance;

    modport source (output valid, encoder_count, time_us, target_speed, clear_distance,
                    input ready);
    modport sink   (input valid, encoder_count, time_us, target_speed, clear_distance,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/esl_out_if.sv
// ----------------------------------------------------------------------------
// esl_out_if
// Result channel: drive, measured speed, odometer, zero-interval flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface esl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_percent;
    logic signed [15:0] measured_speed;
    logic signed [31:0] distance_traveled;
    logic               zero_interval;

    modport source (output valid, drive_percent, measured_speed, distance_traveled,
                    zero_interval, input ready);
    modport sink   (input valid, drive_percent, measured_speed, distance_traveled,
                    zero_interval, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/encoder_speed_loop.sv
// ----------------------------------------------------------------------------
// encoder_speed_loop
// Encoder odometer, speed measurement and integral drive loop per tick.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_ch     in   encoder_count, time_us, target_speed, clear_distance
//  out_ch    out  drive_percent, measured_speed, distance_traveled, zero_interval
//  apb       in   distance_per_count @0x0, loop_gain @0x4
//
//  From an accepted tick the sequencer runs three shared 32x16 multiplier
//  passes, the sum, the divider (start, 17 quotient bits, done), the error
//  step, a fourth multiplier pass and the drive step. When elapsed time is
//  zero, the sum step goes straight to the error step and skips the divider.
//  in_ch is ready only when the sequencer is idle. A result waits in the
//  output register; a stalled out_ch holds the sequencer in its last step.
//  Reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_speed_loop_macros.svh"

module encoder_speed_loop (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    esl_in_if.sink                           in_ch,
    esl_out_if.source                        out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [esl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    esl_pkg::cfg_t       cfg;
    esl_pkg::div_stat_t  div_stat;
    esl_pkg::state_t     state_reg, state_next;

    logic                in_ready;
    logic                div_start;
    logic                slot_free;
    logic                in_beat;
    logic                out_load;

    // tick state
    logic [31:0]         last_count_reg;
    logic [31:0]         last_time_reg;
    logic signed [31:0]  odo_reg;
    logic signed [15:0]  drive_reg;

    // per-item working registers
    logic [31:0]                        dmag_reg;
    logic                               dsign_reg;
    logic [31:0]                        dt_reg;
    logic                               zero_reg;
    logic signed [15:0]                 target_reg;
    logic                               clear_reg;
    logic                               step_neg_reg;
    logic [23:0]                        step_hi_reg;
    logic [37:0]                        num_lo_reg;
    logic [esl_pkg::NUM_W-1:0]          num_reg;
    logic [esl_pkg::PROD_W-1:0]         mul_reg;
    logic signed [15:0]                 speed_reg;
    logic [15:0]                        err_mag_reg;
    logic                               err_neg_reg;

    // output register
    logic                out_valid_reg;
    logic signed [15:0]  out_drive_reg;
    logic signed [15:0]  out_speed_reg;
    logic signed [31:0]  out_dist_reg;
    logic                out_zero_reg;

    logic [esl_pkg::DIV_Q_W-1:0] div_q;

    // ------------------------------------------------------------------ cfg
    esl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // -------------------------------------------------------------- divider
    esl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   ({dt_reg, 2'b00}),
        .quot  (div_q),
        .stat  (div_stat)
    );

    // ------------------------------------------------------------ sequencer
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_beat   = in_ch.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= esl_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esl_pkg::S_IDLE:     if (in_ch.valid) state_next = esl_pkg::S_STEP;
            esl_pkg::S_STEP:     state_next = esl_pkg::S_SCALE_LO;
            esl_pkg::S_SCALE_LO: state_next = esl_pkg::S_SCALE_HI;
            esl_pkg::S_SCALE_HI: state_next = esl_pkg::S_SUM;
            esl_pkg::S_SUM:      state_next = zero_reg ? esl_pkg::S_ERR : esl_pkg::S_DIV_GO;
            esl_pkg::S_DIV_GO:   state_next = esl_pkg::S_DIV_WAIT;
            esl_pkg::S_DIV_WAIT: if (div_stat.done) state_next = esl_pkg::S_ERR;
            esl_pkg::S_ERR:      state_next = esl_pkg::S_CORR;
            esl_pkg::S_CORR:     state_next = esl_pkg::S_DRIVE;
            esl_pkg::S_DRIVE:    if (slot_free) state_next = esl_pkg::S_IDLE;
            default:             state_next = esl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            esl_pkg::S_IDLE:   in_ready  = 1'b1;
            esl_pkg::S_DIV_GO: div_start = 1'b1;
            esl_pkg::S_DRIVE:  out_load  = slot_free;
            default:           in_ready  = 1'b0;
        endcase
    end

    assign in_ch.ready = in_ready;

    // ------------------------------------------------------ shared multiplier
    logic [31:0]                 mul_a;
    logic [15:0]                 mul_b;
    logic [esl_pkg::PROD_W-1:0]  mul_p;

    always_comb
    begin
        case (state_reg)
            esl_pkg::S_STEP:
            begin
                mul_a = dmag_reg;
                mul_b = cfg.dpc;
            end
            esl_pkg::S_SCALE_LO:
            begin
                mul_a = {8'd0, mul_reg[23:0]};
                mul_b = esl_pkg::SPEED_SCALE;
            end
            esl_pkg::S_SCALE_HI:
            begin
                mul_a = {8'd0, step_hi_reg};
                mul_b = esl_pkg::SPEED_SCALE;
            end
            esl_pkg::S_CORR:
            begin
                mul_a = {16'd0, err_mag_reg};
                mul_b = cfg.gain;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------- tick front end
    logic [31:0] dcount;

    assign dcount = in_ch.encoder_count - last_count_reg;

    // -------------------------------------------------------------- odometer
    logic signed [48:0] step_s;
    logic signed [48:0] odo_base;
    logic signed [49:0] odo_sum;
    logic signed [31:0] odo_next;

    always_comb
    begin
        step_s   = step_neg_reg ? -$signed({1'b0, mul_reg}) : $signed({1'b0, mul_reg});
        odo_base = clear_reg ? 49'sd0 : 49'(odo_reg);
        odo_sum  = 50'(odo_base) + 50'(step_s);
        if (odo_sum > 50'sd2147483647)
            odo_next = 32'sh7FFFFFFF;
        else if (odo_sum < -50'sd2147483648)
            odo_next = 32'sh80000000;
        else
            odo_next = odo_sum[31:0];
    end

    // ----------------------------------------------------------------- speed
    logic signed [15:0] speed_next;
    logic signed [16:0] err;
    logic               pos_big;
    logic               neg_big;
    logic [16:0]        q_neg;

    always_comb
    begin
        pos_big = div_stat.sat || (div_q > 17'd32767);
        neg_big = div_stat.sat || (div_q > 17'd32768);
        q_neg   = ~div_q + 17'd1;
        if (zero_reg)
            speed_next = 16'sd0;
        else if (!step_neg_reg)
            speed_next = pos_big ? 16'sh7FFF : div_q[15:0];
        else
            speed_next = neg_big ? 16'sh8000 : q_neg[15:0];
        err = 17'(target_reg) - 17'(speed_next);
    end

    // ----------------------------------------------------------------- drive
    logic signed [25:0] corr_s;
    logic signed [25:0] drive_sum;
    logic signed [15:0] drive_next;

    always_comb
    begin
        corr_s    = $signed({2'b00, mul_reg[31:8]});
        drive_sum = err_neg_reg ? (26'(drive_reg) - corr_s) : (26'(drive_reg) + corr_s);
        if (target_reg == 16'sd0)
            drive_next = 16'sd0;
        else if (drive_sum > esl_pkg::DRIVE_MAX)
            drive_next = esl_pkg::DRIVE_MAX[15:0];
        else if (drive_sum < esl_pkg::DRIVE_MIN)
            drive_next = esl_pkg::DRIVE_MIN[15:0];
        else
            drive_next = drive_sum[15:0];
    end

    // ------------------------------------------------------ state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            last_time_reg  <= '0;
            odo_reg        <= '0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                last_count_reg <= in_ch.encoder_count;
                last_time_reg  <= in_ch.time_us;
            end
            if (state_reg == esl_pkg::S_SCALE_LO)
                odo_reg <= odo_next;
            if (out_load)
            begin
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------ working registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            dsign_reg  <= dcount[31];
            dmag_reg   <= dcount[31] ? (~dcount + 32'd1) : dcount;
            dt_reg     <= in_ch.time_us - last_time_reg;
            zero_reg   <= (in_ch.time_us == last_time_reg);
            target_reg <= in_ch.target_speed;
            clear_reg  <= in_ch.clear_distance;
        end
        case (state_reg)
            esl_pkg::S_STEP:
            begin
                mul_reg      <= mul_p;
                step_neg_reg <= dsign_reg ^ drive_reg[15];
            end
            esl_pkg::S_SCALE_LO:
            begin
                step_hi_reg <= mul_reg[47:24];
                mul_reg     <= mul_p;
            end
            esl_pkg::S_SCALE_HI:
            begin
                num_lo_reg <= mul_reg[37:0];
                mul_reg    <= mul_p;
            end
            esl_pkg::S_SUM:
                num_reg <= {mul_reg[37:0], 24'd0} + {24'd0, num_lo_reg};
            esl_pkg::S_ERR:
            begin
                speed_reg   <= speed_next;
                err_neg_reg <= err[16];
                err_mag_reg <= err[16] ? 16'(-err) : err[15:0];
            end
            esl_pkg::S_CORR:
                mul_reg <= mul_p;
            default:
                num_reg <= num_reg;
        endcase
        if (out_load)
        begin
            out_drive_reg <= drive_next;
            out_speed_reg <= speed_reg;
            out_dist_reg  <= odo_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.drive_percent     = out_drive_reg;
    assign out_ch.measured_speed    = out_speed_reg;
    assign out_ch.distance_traveled = out_dist_reg;
    assign out_ch.zero_interval     = out_zero_reg;

    // ------------------------------------------------------------ assertions
    `ESL_ASSERT_IMP(a_drive_bound, clk, rst_n, 1'b1, (drive_reg <= 16'sd25600) && (drive_reg >= -16'sd25600), "drive out of range")
    `ESL_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_beat, !in_ch.ready, "ready during tick work")
    `ESL_ASSERT_IMP(a_zero_speed, clk, rst_n, out_valid_reg && out_zero_reg, out_speed_reg == 16'sd0, "speed nonzero on zero interval")

endmodule

`default_nettype wire

// File: hw/rtl/esl_cfg.sv
// ----------------------------------------------------------------------------
// esl_cfg
// APB register file: distance per count and loop gain.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [esl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output esl_pkg::cfg_t                    cfg
);

    logic [esl_pkg::DPC_W-1:0]  dpc_reg;
    logic [esl_pkg::GAIN_W-1:0] gain_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg  <= esl_pkg::DPC_RESET;
            gain_reg <= esl_pkg::GAIN_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                esl_pkg::REG_DPC:  dpc_reg  <= pwdata[esl_pkg::DPC_W-1:0];
                esl_pkg::REG_GAIN: gain_reg <= pwdata[esl_pkg::GAIN_W-1:0];
                default:           dpc_reg  <= dpc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            esl_pkg::REG_DPC:  prdata = {16'd0, dpc_reg};
            esl_pkg::REG_GAIN: prdata = {16'd0, gain_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.dpc  = dpc_reg;
    assign cfg.gain = gain_reg;

endmodule

`default_nettype wire

// File: hw/rtl/esl_div.sv
// ----------------------------------------------------------------------------
// esl_div
// Restoring divider, one quotient bit per cycle, 17 bits plus overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [esl_pkg::NUM_W-1:0]     num,
    input  wire logic [esl_pkg::DIV_D_W-1:0]   den,
    output logic [esl_pkg::DIV_Q_W-1:0]        quot,
    output esl_pkg::div_stat_t                 stat
);

    localparam int QW = esl_pkg::DIV_Q_W;
    localparam int DW = esl_pkg::DIV_D_W;
    localparam int NW = esl_pkg::NUM_W;

    logic                            busy_reg;
    logic                            done_reg;
    logic [esl_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   den_reg;
    logic [QW-1:0]                   q_reg;
    logic                            sat_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, q_reg[QW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= esl_pkg::DIV_CNT_W'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient of 2^17 or more saturates the speed anyway
            sat_reg <= (num[NW-1:QW] >= {{(NW-QW-DW){1'b0}}, den});
            rem_reg <= num[QW+DW-1:QW];
            q_reg   <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign quot      = q_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

`default_nettype wire
